[sv/dod_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dod_pkg;

    // field widths
    localparam int OFF_W   = 16;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;

    localparam int OFFSET_BITS_DEF = 16;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // day numbers count from march of year -400 (years biased by 400)
    localparam int YEAR_BIAS = 400;
    localparam int YB_W      = 15;
    localparam int DN_W      = 23;
    localparam int DC_W      = 22;
    localparam int ERA_DAYS  = 146097;
    localparam int ERA_W     = 5;
    localparam int ERAY_W    = 14;
    localparam int DOE_W     = 18;
    localparam int YOE_W     = 9;
    localparam int DOY_W     = 9;
    localparam int MP_W      = 4;
    localparam int DV_W      = 11;

    // day numbers of 0000-01-01 and 9999-12-31
    localparam logic [DC_W-1:0] LO_DAYS = 22'd146037;
    localparam logic [DC_W-1:0] HI_DAYS = 22'd3798461;

    // the 1970 epoch sits on day number 1 mod 7 and was a thursday
    localparam int WDAY_ADJ = 3;

    // pipeline depths
    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 9;

    // reciprocal constants: exact floor division for inputs below 2**n
    localparam int Y100_SH = YB_W + $clog2(100);
    localparam longint unsigned Y100_RCP = ((64'd1 << Y100_SH) + 64'd99) / 64'd100;
    localparam int Y100_PW = YB_W + $clog2(Y100_RCP + 1);

    localparam int ERA_SH = DC_W + $clog2(ERA_DAYS);
    localparam longint unsigned ERA_RCP =
        ((64'd1 << ERA_SH) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS);
    localparam int ERA_PW = DC_W + $clog2(ERA_RCP + 1);

    localparam int D1460_SH = DOE_W + $clog2(1460);
    localparam longint unsigned D1460_RCP = ((64'd1 << D1460_SH) + 64'd1459) / 64'd1460;
    localparam int D1460_PW = DOE_W + $clog2(D1460_RCP + 1);

    localparam int D36524_SH = DOE_W + $clog2(36524);
    localparam longint unsigned D36524_RCP =
        ((64'd1 << D36524_SH) + 64'd36523) / 64'd36524;
    localparam int D36524_PW = DOE_W + $clog2(D36524_RCP + 1);

    localparam int D365_SH = DOE_W + $clog2(365);
    localparam longint unsigned D365_RCP = ((64'd1 << D365_SH) + 64'd364) / 64'd365;
    localparam int D365_PW = DOE_W + $clog2(D365_RCP + 1);

    localparam int Q100_SH = YOE_W + $clog2(100);
    localparam longint unsigned Q100_RCP = ((64'd1 << Q100_SH) + 64'd99) / 64'd100;
    localparam int Q100_PW = YOE_W + $clog2(Q100_RCP + 1);

    localparam int D153_SH = DV_W + $clog2(153);
    localparam longint unsigned D153_RCP = ((64'd1 << D153_SH) + 64'd152) / 64'd153;
    localparam int D153_PW = DV_W + $clog2(D153_RCP + 1);

    // linear day number handed from the front end to the date split
    typedef struct packed {
        logic [DC_W-1:0] dn;
        logic            flag;
    } dod_link_t;

    // resulting date
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  wday;
        logic               flag;
    } dod_date_t;

    // month 0..15 to march-based month index, wrapping into the neighbouring year
    function automatic logic [MP_W-1:0] month_to_mp(input logic [MONTH_W-1:0] mon);
        logic [MP_W-1:0] mp;
        unique case (mon)
            4'd0:    mp = 4'd9;
            4'd1:    mp = 4'd10;
            4'd2:    mp = 4'd11;
            4'd13:   mp = 4'd10;
            4'd14:   mp = 4'd11;
            4'd15:   mp = 4'd0;
            default: mp = mon - 4'd3;
        endcase
        return mp;
    endfunction

    // first day of a march-based month within its year
    function automatic logic [DOY_W-1:0] mp_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[sv/dod_civil.sv]
`timescale 1ns / 1ps
`default_nettype none

module dod_civil
    import dod_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dod_link_t in_day,
    output logic           out_valid,
    input  wire logic      out_ready,
    output dod_date_t      out_date
);

    typedef struct packed {
        logic [DC_W-1:0]   n;
        logic              flag;
        logic [ERA_W-1:0]  era;
        logic [5:0]        wsum;
        logic [WDAY_W-1:0] wd;
        logic [DOE_W-1:0]  doe;
        logic [ERAY_W-1:0] eray;
        logic [6:0]        a;
        logic [2:0]        b;
        logic              c;
        logic [DOE_W-1:0]  t;
        logic [YOE_W-1:0]  yoe;
        logic [DOE_W-1:0]  y365;
        logic [1:0]        yq;
        logic [DOY_W-1:0]  doy;
        logic [MP_W-1:0]   mp;
        logic [YEAR_W-1:0] year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]  day;
    } back_t;

    back_t                  st_reg  [BACK_STAGES];
    back_t                  st_next [BACK_STAGES];
    logic [BACK_STAGES-1:0] vld_reg;
    logic [BACK_STAGES-1:0] vld_next;
    logic [BACK_STAGES:0]   adv;

    logic [ERA_PW-1:0]    era_prod;
    logic [D1460_PW-1:0]  a_prod;
    logic [D36524_PW-1:0] b_prod;
    logic [D365_PW-1:0]   yoe_prod;
    logic [Q100_PW-1:0]   yq_prod;
    logic [DV_W-1:0]      dv;
    logic [D153_PW-1:0]   mp_prod;
    logic [23:0]          n_ext;
    logic [3:0]           wfold;

    // stage advance chain: a stage loads when empty or when its item moves on
    always_comb begin
        adv[BACK_STAGES] = out_ready;
        for (int i = BACK_STAGES - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < BACK_STAGES; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end else begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[BACK_STAGES-1];

    // datapath of each stage
    always_comb begin
        // era, and octal digit sum of the day number for the weekday
        n_ext    = {2'b00, in_day.dn};
        era_prod = ERA_PW'(in_day.dn) * ERA_PW'(ERA_RCP);
        st_next[0]      = '0;
        st_next[0].n    = in_day.dn;
        st_next[0].flag = in_day.flag;
        st_next[0].era  = ERA_W'(era_prod >> ERA_SH);
        st_next[0].wsum = 6'(WDAY_ADJ);
        for (int k = 0; k < 8; k++) begin
            st_next[0].wsum = st_next[0].wsum + 6'(n_ext[3*k +: 3]);
        end

        // day of era, era years, weekday fold
        st_next[1]      = st_reg[0];
        st_next[1].doe  = DOE_W'(st_reg[0].n - DC_W'(st_reg[0].era) * DC_W'(ERA_DAYS));
        st_next[1].eray = ERAY_W'(st_reg[0].era) * ERAY_W'(YEAR_BIAS);
        wfold = 4'(st_reg[0].wsum[5:3]) + 4'(st_reg[0].wsum[2:0]);
        st_next[1].wd = (wfold >= 4'd7) ? WDAY_W'(wfold - 4'd7) : WDAY_W'(wfold);

        // leap corrections within the era
        a_prod = D1460_PW'(st_reg[1].doe) * D1460_PW'(D1460_RCP);
        b_prod = D36524_PW'(st_reg[1].doe) * D36524_PW'(D36524_RCP);
        st_next[2]   = st_reg[1];
        st_next[2].a = 7'(a_prod >> D1460_SH);
        st_next[2].b = 3'(b_prod >> D36524_SH);
        st_next[2].c = (st_reg[1].doe == DOE_W'(ERA_DAYS - 1));

        st_next[3]   = st_reg[2];
        st_next[3].t = st_reg[2].doe - DOE_W'(st_reg[2].a) + DOE_W'(st_reg[2].b)
                       - DOE_W'(st_reg[2].c);

        // year of era
        yoe_prod = D365_PW'(st_reg[3].t) * D365_PW'(D365_RCP);
        st_next[4]     = st_reg[3];
        st_next[4].yoe = YOE_W'(yoe_prod >> D365_SH);

        // days before that year within the era
        yq_prod = Q100_PW'(st_reg[4].yoe) * Q100_PW'(Q100_RCP);
        st_next[5]      = st_reg[4];
        st_next[5].y365 = DOE_W'(st_reg[4].yoe) * DOE_W'(365);
        st_next[5].yq   = 2'(yq_prod >> Q100_SH);

        st_next[6]     = st_reg[5];
        st_next[6].doy = DOY_W'(st_reg[5].doe - st_reg[5].y365
                         - DOE_W'(st_reg[5].yoe >> 2) + DOE_W'(st_reg[5].yq));

        // march-based month from day of year
        dv      = (DV_W'(st_reg[6].doy) << 2) + DV_W'(st_reg[6].doy) + DV_W'(2);
        mp_prod = D153_PW'(dv) * D153_PW'(D153_RCP);
        st_next[7]    = st_reg[6];
        st_next[7].mp = MP_W'(mp_prod >> D153_SH);

        // calendar fields, january and february belong to the next year
        st_next[8]       = st_reg[7];
        st_next[8].day   = DAY_W'(st_reg[7].doy - mp_start(st_reg[7].mp) + DOY_W'(1));
        st_next[8].month = (st_reg[7].mp < MP_W'(10)) ? st_reg[7].mp + MP_W'(3)
                                                        : st_reg[7].mp - MP_W'(9);
        st_next[8].year  = ERAY_W'(st_reg[7].eray + ERAY_W'(st_reg[7].yoe)
                           + ERAY_W'(st_reg[7].mp >= MP_W'(10)) - ERAY_W'(YEAR_BIAS));
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < BACK_STAGES; i++) begin
            if (adv[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_date.year  = st_reg[BACK_STAGES-1].year;
    assign out_date.month = st_reg[BACK_STAGES-1].month;
    assign out_date.day   = st_reg[BACK_STAGES-1].day;
    assign out_date.wday  = st_reg[BACK_STAGES-1].wd;
    assign out_date.flag  = st_reg[BACK_STAGES-1].flag;

endmodule

`default_nettype wire

[sv/date_offset_days_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Moves a proleptic Gregorian date forward or backward by up to 65535 days and
// returns the resulting date, its weekday (0 Sunday .. 6 Saturday) and a flag
// that is set when the result fell outside 0000-01-01 .. 9999-12-31 and was
// pinned to that bound. Day and month values past their limits roll over into
// the following months and years, day zero meaning the last day of the month
// before. The unit takes one item every clock cycle unless back-pressure at
// the output holds it back: four stages turn the date into a linear day
// number, apply the offset and clamp it, and nine stages split the day
// number back into year, month and day. Every stage holds its item under
// back-pressure and empty stages keep filling, so input flow continues while
// a result waits at the output until all thirteen stages hold an item.
module date_offset_days_unit
    import dod_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // year_in, month_in, day_in, offset_days, zero pad
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // operation
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // year_out, month_out, day_out, weekday_out, zero pad
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // out_of_range
    output logic                      m_axis_tuser
);

    localparam int OFF_USE = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;
    localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((17'd1 << OFF_USE) - 17'd1);

    typedef struct packed {
        logic             sub;
        logic [OFF_W-1:0] off;
        logic [DN_W-1:0]  y365;
        logic [YB_W-3:0]  y4;
        logic [7:0]       q100;
        logic [DOY_W-1:0] doyd;
        logic [DN_W-1:0]  base;
        logic [DN_W-1:0]  n;
        logic [DC_W-1:0]  dn;
        logic             flag;
    } front_t;

    front_t                  fr_reg  [FRONT_STAGES];
    front_t                  fr_next [FRONT_STAGES];
    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;
    logic [FRONT_STAGES:0]   adv;

    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [OFF_W-1:0]   in_off;
    logic [MP_W-1:0]    in_mp;
    logic [YB_W-1:0]    in_yb;
    logic [Y100_PW-1:0] y100_prod;

    logic      link_ready;
    dod_link_t link_day;
    dod_date_t res;

    assign in_year  = s_axis_tdata[13:0];
    assign in_month = s_axis_tdata[17:14];
    assign in_day   = s_axis_tdata[22:18];
    assign in_off   = s_axis_tdata[38:23] & OFF_MASK;

    // stage advance chain
    always_comb begin
        adv[FRONT_STAGES] = link_ready;
        for (int i = FRONT_STAGES - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? s_axis_tvalid : vld_reg[0];
        for (int i = 1; i < FRONT_STAGES; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end else begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    assign s_axis_tready = adv[0];

    // datapath of each stage
    always_comb begin
        // month zero is december before, months thirteen to fifteen the next year;
        // january and february count with the year before (march-based years)
        in_mp = month_to_mp(in_month);
        in_yb = YB_W'(in_year) + YB_W'(YEAR_BIAS) - YB_W'(in_month <= MONTH_W'(2))
                + YB_W'(in_month == MONTH_W'(15));
        y100_prod = Y100_PW'(in_yb) * Y100_PW'(Y100_RCP);

        fr_next[0]      = '0;
        fr_next[0].sub  = s_axis_tuser;
        fr_next[0].off  = in_off;
        fr_next[0].y365 = DN_W'(in_yb) * DN_W'(365);
        fr_next[0].y4   = in_yb[YB_W-1:2];
        fr_next[0].q100 = 8'(y100_prod >> Y100_SH);
        fr_next[0].doyd = mp_start(in_mp) + DOY_W'(in_day);

        // day number of the start date
        fr_next[1]      = fr_reg[0];
        fr_next[1].base = fr_reg[0].y365 + DN_W'(fr_reg[0].y4) - DN_W'(fr_reg[0].q100)
                          + DN_W'(fr_reg[0].q100 >> 2) + DN_W'(fr_reg[0].doyd) - DN_W'(1);

        // apply the offset
        fr_next[2]   = fr_reg[1];
        fr_next[2].n = fr_reg[1].sub ? fr_reg[1].base - DN_W'(fr_reg[1].off)
                                     : fr_reg[1].base + DN_W'(fr_reg[1].off);

        // pin to the supported year range
        fr_next[3] = fr_reg[2];
        if (fr_reg[2].n < DN_W'(LO_DAYS)) begin
            fr_next[3].dn   = LO_DAYS;
            fr_next[3].flag = 1'b1;
        end else if (fr_reg[2].n > DN_W'(HI_DAYS)) begin
            fr_next[3].dn   = HI_DAYS;
            fr_next[3].flag = 1'b1;
        end else begin
            fr_next[3].dn   = DC_W'(fr_reg[2].n);
            fr_next[3].flag = 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < FRONT_STAGES; i++) begin
            if (adv[i]) begin
                fr_reg[i] <= fr_next[i];
            end
        end
    end

    assign link_day.dn   = fr_reg[FRONT_STAGES-1].dn;
    assign link_day.flag = fr_reg[FRONT_STAGES-1].flag;

    // day number back to calendar date
    dod_civil u_civil (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[FRONT_STAGES-1]),
        .in_ready  (link_ready),
        .in_day    (link_day),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_date  (res)
    );

    assign m_axis_tdata = {6'b000000, res.wday, res.day, res.month, res.year};
    assign m_axis_tuser = res.flag;

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import dod_pkg::*;

    // direction of the shift, carried on s_axis_tuser
    typedef enum bit {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } date_op_t;

    // one input item before packing
    typedef struct {
        date_op_t           op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [OFF_W-1:0]   off;
    } date_item_t;

    // bit positions within the result tdata
    localparam int M_MONTH_LSB = YEAR_W;
    localparam int M_DAY_LSB   = M_MONTH_LSB + MONTH_W;
    localparam int M_WDAY_LSB  = M_DAY_LSB + DAY_W;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    date_item_t pending_items[$];
    dod_date_t  expected_dates[$];
    date_item_t next_item;
    date_item_t taken_item;
    dod_date_t  got_date;
    dod_date_t  want_date;

    int seen_in     = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches  = 0;
    int items_in    = 0;
    int results_out = 0;
    int saturated   = 0;
    int directed_n  = 0;

    date_offset_days_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // linear day number from march of year zero, year already biased
    function automatic longint day_number(longint y, longint m, longint d);
        longint era, yoe, mp, doy, doe;
        if (m <= 2)
            y = y - 1;
        era = y / 400;
        yoe = y - era * 400;
        mp  = (m + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * ERA_DAYS + doe;
    endfunction

    // expected result of shifting one date by its offset
    function automatic dod_date_t shift_date(date_item_t it);
        longint year, mon0, off, n, lo, hi, era, doe, yoe, doy, mp, yy, epoch;
        dod_date_t r;
        year = it.year;
        mon0 = longint'(it.month) - 1;
        off  = it.off;
        off  = off & ((longint'(1) << OFFSET_BITS_DEF) - 1);
        // month zero and months past december wrap into the neighbouring year
        if (mon0 < 0) begin
            mon0 += 12;
            year -= 1;
        end else if (mon0 >= 12) begin
            mon0 -= 12;
            year += 1;
        end
        year += YEAR_BIAS;
        n = day_number(year, mon0 + 1, 1) + longint'(it.day) - 1;
        if (it.op == OP_SUB)
            n -= off;
        else
            n += off;
        // pin to 0000-01-01 .. 9999-12-31
        lo = day_number(YEAR_BIAS, 1, 1);
        hi = day_number(YEAR_BIAS + 9999, 12, 31);
        r.flag = 1'b0;
        if (n < lo) begin
            n = lo;
            r.flag = 1'b1;
        end else if (n > hi) begin
            n = hi;
            r.flag = 1'b1;
        end
        // split the day number back into a date
        era = n / ERA_DAYS;
        doe = n - era * ERA_DAYS;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        yy  = yoe + era * 400;
        r.day   = DAY_W'(doy - (153 * mp + 2) / 5 + 1);
        r.month = MONTH_W'((mp < 10) ? mp + 3 : mp - 9);
        if (r.month <= 2)
            yy += 1;
        r.year = YEAR_W'(yy - YEAR_BIAS);
        // 1970-01-01 was a thursday
        epoch  = day_number(YEAR_BIAS + 1970, 1, 1);
        r.wday = WDAY_W'(((n - epoch) % 7 + 7 + 4) % 7);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s, got %0d expected %0d (result %0d)",
                 $time, what, got, want, results_out);
        mismatches++;
    endtask

    task automatic add_item(input date_op_t op, input int y, input int m, input int d,
                            input int off);
        date_item_t it;
        it.op    = op;
        it.year  = YEAR_W'(y);
        it.month = MONTH_W'(m);
        it.day   = DAY_W'(d);
        it.off   = OFF_W'(off);
        pending_items.push_back(it);
    endtask

    // mostly well-formed dates, some pushed towards the bounds, the rest raw fields
    task automatic add_random(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                add_item(date_op_t'($urandom_range(1)), $urandom_range(9999),
                         $urandom_range(12, 1), $urandom_range((pick < 40) ? 28 : 31, 1),
                         ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                  : $urandom_range(400));
            end else if (pick < 80) begin
                if ($urandom_range(1))
                    add_item(OP_SUB, $urandom_range(180), $urandom_range(12, 1),
                             $urandom_range(31, 1), $urandom_range(65535));
                else
                    add_item(OP_ADD, 9999 - $urandom_range(180), $urandom_range(12, 1),
                             $urandom_range(31, 1), $urandom_range(65535));
            end else begin
                add_item(date_op_t'($urandom_range(1)), $urandom_range(16383),
                         $urandom_range(15), $urandom_range(31), $urandom_range(65535));
            end
        end
    endtask

    // sender holds off until every item has come back out
    task automatic wait_for_drain();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_dates.size() != 0)
            @(posedge aclk);
    endtask

    // driver: new item or idle at the falling edge, random receiver stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || items_in != seen_in) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, next_item.off, next_item.day, next_item.month,
                                      next_item.year};
                    s_axis_tuser  <= next_item.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
        seen_in = items_in;
    end

    // monitor: record accepted items and check each result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                taken_item.op    = date_op_t'(s_axis_tuser);
                taken_item.year  = s_axis_tdata[YEAR_W-1:0];
                taken_item.month = s_axis_tdata[YEAR_W +: MONTH_W];
                taken_item.day   = s_axis_tdata[YEAR_W+MONTH_W +: DAY_W];
                taken_item.off   = s_axis_tdata[YEAR_W+MONTH_W+DAY_W +: OFF_W];
                expected_dates.push_back(shift_date(taken_item));
                items_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_date.year  = m_axis_tdata[YEAR_W-1:0];
                got_date.month = m_axis_tdata[M_MONTH_LSB +: MONTH_W];
                got_date.day   = m_axis_tdata[M_DAY_LSB +: DAY_W];
                got_date.wday  = m_axis_tdata[M_WDAY_LSB +: WDAY_W];
                got_date.flag  = m_axis_tuser;
                if (expected_dates.size() == 0) begin
                    report_mismatch("result with nothing pending, year", got_date.year, 0);
                end else begin
                    want_date = expected_dates.pop_front();
                    if (got_date.year != want_date.year)
                        report_mismatch("year_out", got_date.year, want_date.year);
                    if (got_date.month != want_date.month)
                        report_mismatch("month_out", got_date.month, want_date.month);
                    if (got_date.day != want_date.day)
                        report_mismatch("day_out", got_date.day, want_date.day);
                    if (got_date.wday != want_date.wday)
                        report_mismatch("weekday_out", got_date.wday, want_date.wday);
                    if (got_date.flag != want_date.flag)
                        report_mismatch("out_of_range", got_date.flag, want_date.flag);
                end
                if (got_date.flag)
                    saturated++;
                results_out++;
            end
        end
    end

    // stimulus and phase control
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: bounds, saturation, rollover of day and month, oversized years
        tx_idle_pct = 12;
        rx_idle_pct = 78;
        add_item(OP_ADD, 0, 1, 1, 0);
        add_item(OP_SUB, 0, 1, 1, 1);
        add_item(OP_ADD, 9999, 12, 31, 0);
        add_item(OP_ADD, 9999, 12, 31, 1);
        add_item(OP_SUB, 0, 3, 1, 65535);
        add_item(OP_ADD, 9999, 1, 1, 65535);
        add_item(OP_ADD, 2023, 2, 31, 0);
        add_item(OP_ADD, 2024, 3, 0, 0);
        add_item(OP_ADD, 2000, 0, 15, 0);
        add_item(OP_ADD, 1999, 13, 1, 0);
        add_item(OP_ADD, 1999, 14, 29, 0);
        add_item(OP_SUB, 1999, 15, 31, 3);
        add_item(OP_SUB, 10100, 1, 1, 65535);
        add_item(OP_ADD, 1900, 2, 28, 1);
        add_item(OP_ADD, 2000, 2, 28, 1);
        add_item(OP_ADD, 1970, 1, 1, 0);
        add_item(OP_ADD, 0, 0, 0, 5);
        add_item(OP_SUB, 16383, 15, 31, 65535);
        add_item(OP_ADD, 16383, 15, 31, 65535);
        add_item(OP_SUB, 0, 0, 0, 0);
        add_item(OP_ADD, 0, 0, 31, 65535);
        directed_n = pending_items.size();
        wait_for_drain();

        add_random(700);
        wait_for_drain();

        tx_idle_pct = 78;
        rx_idle_pct = 12;
        add_random(700);
        wait_for_drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random(600);
        wait_for_drain();

        // let any stray result show up
        repeat (40) @(posedge aclk);

        $display("covered %0d items (%0d directed), %0d results checked, %0d pinned to a bound",
                 items_in, directed_n, results_out, saturated);
        $display("idling sender/receiver: 12/78, 78/12 and 0/0 percent, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_dates.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_dates.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[date_offset_days_unit.f]
sv/dod_pkg.sv
sv/dod_civil.sv
sv/date_offset_days_unit.sv
test/testbench.sv
